FILE: rtl/assert_macros.svh
// assertion helpers included by box_filter_downsampler
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define BFD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// condition must never be seen outside reset
`define BFD_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`else

`define BFD_ASSERT(lbl, prop)
`define BFD_ASSERT_NEVER(lbl, cond)

`endif

`endif

FILE: rtl/bfd_pkg.sv
`default_nettype none

package bfd_pkg;

  localparam int MAX_OUT_WIDTH = 1024;
  localparam int MAX_SCALE     = 3;

  localparam int PIX_W   = 8;
  localparam int SCALE_W = 2;
  localparam int WIDTH_W = 11;
  localparam int COL_W   = $clog2(MAX_OUT_WIDTH);
  // largest block sum plus rounding half must fit
  localparam int SUM_W   = $clog2(MAX_SCALE * MAX_SCALE * 255 + MAX_SCALE * MAX_SCALE);
  localparam int CFG_W   = WIDTH_W;

  // divide by nine as multiply by ceil(2^16 / 9) and shift
  localparam int DIV9_SHIFT = 16;
  localparam int DIV9_MUL   = (65536 + 8) / 9;
  localparam int DIV9_MUL_W = 13;

  // register indexes of the config port
  localparam logic REG_SCALE     = 1'b0;
  localparam logic REG_OUT_WIDTH = 1'b1;

  typedef logic [SUM_W-1:0] sum_t;

  typedef struct packed {
    sum_t b;
    sum_t g;
    sum_t r;
  } sums_t;

endpackage

`default_nettype wire

FILE: rtl/bfd_div.sv
`default_nettype none

module bfd_div (
  input  wire logic [bfd_pkg::SCALE_W-1:0] scale_i,
  input  wire bfd_pkg::sum_t               sum_i,
  output logic [bfd_pkg::PIX_W-1:0]        avg_o
);

  localparam int PROD_W = bfd_pkg::SUM_W + bfd_pkg::DIV9_MUL_W;

  logic [PROD_W-1:0]        prod;
  logic [bfd_pkg::SUM_W-1:0] quo;

  assign prod = PROD_W'(sum_i) * PROD_W'(bfd_pkg::DIV9_MUL);

  always_comb begin
    unique case (scale_i)
      2'd2:    quo = sum_i >> 2;
      2'd3:    quo = bfd_pkg::SUM_W'(prod >> bfd_pkg::DIV9_SHIFT);
      default: quo = sum_i;
    endcase
  end

  assign avg_o = quo[bfd_pkg::PIX_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/box_filter_downsampler.sv
// Box-filter decimator for an RGB raster stream.
// Input stream: one supersampled pixel per transaction, tdata = {blue, green, red},
// tuser = first pixel of a frame (clears the position counters first).
// Output stream: one averaged pixel per scale x scale block, tdata = {blue, green,
// red}, tlast = last output pixel of the row.
// Config port: index 0 = scale (1..3), index 1 = out_width (1..1024); write only
// while no pixel is in flight.
// Column sums live in a 1024 x 36 synchronous RAM; each pixel reads its column,
// adds, and writes back from stage 1, with the last write forwarded to a
// read of the same column. The RAM is not cleared: the first pixel of every
// block overwrites its entry.
// A result moves through the stage 1, stage 2 and output registers to tvalid.
// Throughput: one pixel per cycle unless stalled (single RAM read and write port).
// Reset clears counters and the pipeline, scale to 1 and out_width to 100.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_axis_tready drops until the result is taken.
`default_nettype none

module box_filter_downsampler (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // config write port
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_addr_i,
  input  wire logic [bfd_pkg::CFG_W-1:0]   cfg_wdata_i,
  // pixel input
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [23:0]                 s_axis_tdata,  // red_in, green_in, blue_in
  input  wire logic                        s_axis_tuser,  // first_of_frame
  // averaged output
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [23:0]                      m_axis_tdata,  // red_out, green_out, blue_out
  output logic                             m_axis_tlast   // end_of_row
);

  localparam int COL_W   = bfd_pkg::COL_W;
  localparam int SUM_W   = bfd_pkg::SUM_W;
  localparam int SCALE_W = bfd_pkg::SCALE_W;
  localparam int WIDTH_W = bfd_pkg::WIDTH_W;
  localparam int PIX_W   = bfd_pkg::PIX_W;
  localparam int DEPTH   = bfd_pkg::MAX_OUT_WIDTH;

  // config registers
  logic [SCALE_W-1:0] scale_q;
  logic [WIDTH_W-1:0] width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_W'(1);
      width_q <= WIDTH_W'(100);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        bfd_pkg::REG_SCALE:     scale_q <= cfg_wdata_i[SCALE_W-1:0];
        bfd_pkg::REG_OUT_WIDTH: width_q <= cfg_wdata_i[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  logic [SCALE_W-1:0] s_eff;
  logic [WIDTH_W-1:0] w_eff;
  logic [WIDTH_W-1:0] w_last;

  always_comb begin
    if (scale_q == '0) begin
      s_eff = SCALE_W'(1);
    end else if (scale_q > SCALE_W'(bfd_pkg::MAX_SCALE)) begin
      s_eff = SCALE_W'(bfd_pkg::MAX_SCALE);
    end else begin
      s_eff = scale_q;
    end
    if (width_q == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (width_q > WIDTH_W'(DEPTH)) begin
      w_eff = WIDTH_W'(DEPTH);
    end else begin
      w_eff = width_q;
    end
  end

  assign w_last = w_eff - WIDTH_W'(1);

  // pipeline advance: everything moves together when the output slot is free
  logic adv;
  logic accept;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;

  // position counters and stage 0 decode
  logic [COL_W-1:0]   out_col_q, out_col_d, oc;
  logic [SCALE_W-1:0] sub_col_q, sub_col_d, sc;
  logic [SCALE_W-1:0] sub_row_q, sub_row_d, sr;
  logic               last_col_row, last_col_blk, last_row_blk, first_blk;
  logic [COL_W-1:0]   col;

  always_comb begin
    oc = s_axis_tuser ? '0 : out_col_q;
    sc = s_axis_tuser ? '0 : sub_col_q;
    sr = s_axis_tuser ? '0 : sub_row_q;

    last_col_row = {1'b0, oc} >= w_last;
    col          = last_col_row ? w_last[COL_W-1:0] : oc;
    last_col_blk = sc >= s_eff - SCALE_W'(1);
    last_row_blk = sr >= s_eff - SCALE_W'(1);
    first_blk    = (sc == '0) && (sr == '0);

    out_col_d = oc;
    sub_col_d = sc;
    sub_row_d = sr;
    if (last_col_blk) begin
      sub_col_d = '0;
      if (last_col_row) begin
        out_col_d = '0;
        sub_row_d = last_row_blk ? '0 : sr + SCALE_W'(1);
      end else begin
        out_col_d = oc + COL_W'(1);
      end
    end else begin
      sub_col_d = sc + SCALE_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_col_q <= '0;
      sub_col_q <= '0;
      sub_row_q <= '0;
    end else if (accept) begin
      out_col_q <= out_col_d;
      sub_col_q <= sub_col_d;
      sub_row_q <= sub_row_d;
    end
  end

  // stage 1: sum read back, add, write
  logic               s1_valid_q;
  logic               s1_first_q, s1_emit_q, s1_eor_q;
  logic [COL_W-1:0]   s1_col_q;
  logic [23:0]        s1_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_first_q <= first_blk;
      s1_emit_q  <= last_col_blk && last_row_blk;
      s1_eor_q   <= last_col_row;
      s1_col_q   <= col;
      s1_pix_q   <= s_axis_tdata;
    end
  end

  bfd_pkg::sums_t mem_q [DEPTH];
  bfd_pkg::sums_t rd_q;
  bfd_pkg::sums_t old_sum, new_sum;
  logic           wr_en;

  // forwarding of the most recent write
  logic             fwd_valid_q;
  logic [COL_W-1:0] fwd_addr_q;
  bfd_pkg::sums_t   fwd_data_q;

  assign wr_en = adv && s1_valid_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= mem_q[col];
    end
    if (wr_en) begin
      mem_q[s1_col_q] <= new_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (wr_en) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fwd_addr_q <= s1_col_q;
      fwd_data_q <= new_sum;
    end
  end

  always_comb begin
    old_sum = (fwd_valid_q && fwd_addr_q == s1_col_q) ? fwd_data_q : rd_q;
    if (s1_first_q) begin
      new_sum.r = SUM_W'(s1_pix_q[7:0]);
      new_sum.g = SUM_W'(s1_pix_q[15:8]);
      new_sum.b = SUM_W'(s1_pix_q[23:16]);
    end else begin
      new_sum.r = old_sum.r + SUM_W'(s1_pix_q[7:0]);
      new_sum.g = old_sum.g + SUM_W'(s1_pix_q[15:8]);
      new_sum.b = old_sum.b + SUM_W'(s1_pix_q[23:16]);
    end
  end

  // stage 2: rounded sums, then division into the output register
  logic [3:0]         area;
  logic [SUM_W-1:0]   half;
  logic               s2_valid_q, s2_eor_q;
  bfd_pkg::sums_t     s2_sum_q;

  assign area = 4'(s_eff) * 4'(s_eff);
  assign half = SUM_W'(area >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_eor_q   <= s1_eor_q;
      s2_sum_q.r <= new_sum.r + half;
      s2_sum_q.g <= new_sum.g + half;
      s2_sum_q.b <= new_sum.b + half;
    end
  end

  logic [PIX_W-1:0] avg_r, avg_g, avg_b;

  bfd_div u_div_r (.scale_i(s_eff), .sum_i(s2_sum_q.r), .avg_o(avg_r));
  bfd_div u_div_g (.scale_i(s_eff), .sum_i(s2_sum_q.g), .avg_o(avg_g));
  bfd_div u_div_b (.scale_i(s_eff), .sum_i(s2_sum_q.b), .avg_o(avg_b));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_axis_tdata <= {avg_b, avg_g, avg_r};
      m_axis_tlast <= s2_eor_q;
    end
  end

`include "assert_macros.svh"

  // a stalled pipeline keeps its read-modify-write item in place
  `BFD_ASSERT(a_s1_hold, (s1_valid_q && !adv) |=> (s1_valid_q && $stable(s1_col_q)))
  // a block end always reaches the divide stage
  `BFD_ASSERT(a_s2_fill, (adv && s1_valid_q && s1_emit_q) |=> s2_valid_q)
  // a divided result always lands in the output register
  `BFD_ASSERT(a_out_fill, (adv && s2_valid_q) |=> m_axis_tvalid)
  // no RAM write while the output side is stalled
  `BFD_ASSERT_NEVER(a_no_wr_stall, wr_en && m_axis_tvalid && !m_axis_tready)

endmodule

`default_nettype wire

FILE: dv/box_filter_downsampler_checker.sv
`timescale 1ns / 1ps

module box_filter_downsampler_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_addr_i,
  input  logic [bfd_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                      pix_valid_i,
  input  logic                      pix_ready_i,
  input  logic [23:0]               pix_data_i,   // red_in, green_in, blue_in
  input  logic                      pix_first_i,  // first_of_frame
  input  logic                      avg_valid_i,
  input  logic                      avg_ready_i,
  input  logic [23:0]               avg_data_i,   // red_out, green_out, blue_out
  input  logic                      avg_last_i,   // end_of_row
  output int                        fail_count_o,
  output int                        pending_o,
  output int                        checked_o
);

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       row_end;
  } avg_pixel_t;

  // running channel sums per output column, red/green/blue
  int                           col_sums [bfd_pkg::MAX_OUT_WIDTH][3];
  int unsigned                  out_col;
  int unsigned                  sub_col;
  int unsigned                  sub_row;
  logic [bfd_pkg::SCALE_W-1:0]  scale_q;
  logic [bfd_pkg::WIDTH_W-1:0]  width_q;
  avg_pixel_t                   expected_avgs [$];

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    fail_count_o++;
  endtask

  task automatic predict_average(input logic first, input logic [23:0] data);
    int unsigned blk;
    int unsigned row_len;
    int unsigned col;
    int unsigned area;
    bit          row_last;
    bit          blk_col_last;
    bit          blk_row_last;
    int          px [3];
    avg_pixel_t  avg;
    blk     = (scale_q == 0) ? 1 :
              ((scale_q > bfd_pkg::MAX_SCALE) ? bfd_pkg::MAX_SCALE : scale_q);
    row_len = (width_q == 0) ? 1 :
              ((width_q > bfd_pkg::MAX_OUT_WIDTH) ? bfd_pkg::MAX_OUT_WIDTH : width_q);
    px[0] = data[7:0];
    px[1] = data[15:8];
    px[2] = data[23:16];
    if (first) begin
      out_col = 0;
      sub_col = 0;
      sub_row = 0;
    end
    // counters past a lowered limit count as sitting on it
    row_last     = out_col >= row_len - 1;
    col          = row_last ? row_len - 1 : out_col;
    blk_col_last = sub_col >= blk - 1;
    blk_row_last = sub_row >= blk - 1;
    for (int c = 0; c < 3; c++) begin
      if (sub_row == 0 && sub_col == 0) begin
        col_sums[col][c] = px[c];
      end else begin
        col_sums[col][c] += px[c];
      end
    end
    if (blk_col_last && blk_row_last) begin
      area        = blk * blk;
      avg.red     = 8'((col_sums[col][0] + area / 2) / area);
      avg.green   = 8'((col_sums[col][1] + area / 2) / area);
      avg.blue    = 8'((col_sums[col][2] + area / 2) / area);
      avg.row_end = row_last;
      expected_avgs.push_back(avg);
    end
    if (blk_col_last) begin
      sub_col = 0;
      if (row_last) begin
        out_col = 0;
        sub_row = blk_row_last ? 0 : sub_row + 1;
      end else begin
        out_col++;
      end
    end else begin
      sub_col++;
    end
  endtask

  task automatic check_average(input logic [23:0] data, input logic last);
    avg_pixel_t want;
    if (expected_avgs.size() == 0) begin
      report_mismatch($sformatf("unexpected output pixel %06h last %0b", data, last));
    end else begin
      want = expected_avgs.pop_front();
      checked_o++;
      if (data[7:0] !== want.red) begin
        report_mismatch($sformatf("red %0d, expected %0d", data[7:0], want.red));
      end
      if (data[15:8] !== want.green) begin
        report_mismatch($sformatf("green %0d, expected %0d", data[15:8], want.green));
      end
      if (data[23:16] !== want.blue) begin
        report_mismatch($sformatf("blue %0d, expected %0d", data[23:16], want.blue));
      end
      if (last !== want.row_end) begin
        report_mismatch($sformatf("end of row %0b, expected %0b", last, want.row_end));
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_col = 0;
      sub_col = 0;
      sub_row = 0;
      scale_q = bfd_pkg::SCALE_W'(1);
      width_q = bfd_pkg::WIDTH_W'(100);
      expected_avgs.delete();
    end else begin
      if (avg_valid_i && avg_ready_i) begin
        check_average(avg_data_i, avg_last_i);
      end
      if (cfg_we_i) begin
        if (cfg_addr_i == bfd_pkg::REG_SCALE) begin
          scale_q = cfg_wdata_i[bfd_pkg::SCALE_W-1:0];
        end else begin
          width_q = cfg_wdata_i[bfd_pkg::WIDTH_W-1:0];
        end
      end
      if (pix_valid_i && pix_ready_i) begin
        predict_average(pix_first_i, pix_data_i);
      end
    end
    pending_o = expected_avgs.size();
  end

endmodule

FILE: dv/box_filter_downsampler_tb.sv
`timescale 1ns / 1ps

module box_filter_downsampler_tb;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 760;
  localparam int DRAIN_CYCLES = 8;

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      cfg_we_i      = 1'b0;
  logic                      cfg_addr_i    = bfd_pkg::REG_SCALE;
  logic [bfd_pkg::CFG_W-1:0] cfg_wdata_i   = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic [23:0]               s_axis_tdata  = '0;  // red_in, green_in, blue_in
  logic                      s_axis_tuser  = 1'b0;  // first_of_frame
  logic                      m_axis_tready = 1'b0;
  wire                       s_axis_tready;
  wire                       m_axis_tvalid;
  wire  [23:0]               m_axis_tdata;  // red_out, green_out, blue_out
  wire                       m_axis_tlast;  // end_of_row

  int          fail_count;
  int          pending_avgs;
  int          checked_avgs;
  int          cycle_count   = 0;
  int          pixels_sent   = 0;
  int          settings_used = 0;
  bit          quiet         = 1'b0;
  // effective register values seen by the frame generator
  int unsigned cur_scale     = 1;
  int unsigned cur_width     = 100;
  int unsigned frame_pos     = 0;
  int unsigned frame_len     = 1;

  box_filter_downsampler DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  box_filter_downsampler_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .pix_valid_i  (s_axis_tvalid),
    .pix_ready_i  (s_axis_tready),
    .pix_data_i   (s_axis_tdata),
    .pix_first_i  (s_axis_tuser),
    .avg_valid_i  (m_axis_tvalid),
    .avg_ready_i  (m_axis_tready),
    .avg_data_i   (m_axis_tdata),
    .avg_last_i   (m_axis_tlast),
    .fail_count_o (fail_count),
    .pending_o    (pending_avgs),
    .checked_o    (checked_avgs)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= quiet || ($urandom_range(0, 99) >= 28);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d output pixels outstanding",
               cycle_count, pending_avgs);
      $display("box_filter_downsampler test failed");
      $finish;
    end
  end

  function automatic logic [7:0] rand_channel();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_pixel(input logic first, input logic [7:0] red, green, blue);
    while (!quiet && $urandom_range(0, 99) < 28) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {blue, green, red};
    s_axis_tuser  <= first;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pixels_sent++;
  endtask

  // called on the edge of the last transaction; waits until the pipeline is empty
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_avgs != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [bfd_pkg::SCALE_W-1:0] scale,
                            input logic [bfd_pkg::WIDTH_W-1:0] width);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= bfd_pkg::REG_SCALE;
    cfg_wdata_i <= bfd_pkg::CFG_W'(scale);
    @(posedge clk_i);
    cfg_addr_i  <= bfd_pkg::REG_OUT_WIDTH;
    cfg_wdata_i <= bfd_pkg::CFG_W'(width);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_scale = (scale == 0) ? 1 : scale;
    cur_width = (width == 0) ? 1 :
                ((width > bfd_pkg::MAX_OUT_WIDTH) ? bfd_pkg::MAX_OUT_WIDTH : width);
    settings_used++;
  endtask

  task automatic run_phase(input logic [bfd_pkg::SCALE_W-1:0] scale,
                           input logic [bfd_pkg::WIDTH_W-1:0] width,
                           input int n_items);
    int unsigned new_scale;
    int unsigned new_width;
    bit          keep_frame;
    logic        first;
    new_scale = (scale == 0) ? 1 : scale;
    new_width = (width == 0) ? 1 :
                ((width > bfd_pkg::MAX_OUT_WIDTH) ? bfd_pkg::MAX_OUT_WIDTH : width);
    // carrying on mid-frame is only safe when neither limit grows, else a
    // column sum could be read before it was ever written
    keep_frame = new_scale <= cur_scale && new_width <= cur_width && $urandom_range(0, 1);
    set_config(scale, width);
    if (!keep_frame) begin
      frame_pos = 0;
    end
    repeat (n_items) begin
      // rare resync in the middle of a frame
      first = (frame_pos == 0) || ($urandom_range(0, 39) == 0);
      if (first) begin
        frame_pos = 0;
        frame_len = cur_width * cur_scale * cur_scale * $urandom_range(1, 3);
      end
      send_pixel(first, rand_channel(), rand_channel(), rand_channel());
      frame_pos = (frame_pos + 1) % frame_len;
    end
    drain();
  endtask

  initial begin
    int                          random_items;
    int                          phase_idx;
    logic [bfd_pkg::SCALE_W-1:0] scale;
    logic [bfd_pkg::WIDTH_W-1:0] width;
    int                          n_items;
    random_items = 0;
    phase_idx    = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 3x3 blocks, two columns: saturated channels and rounding just below and above a half
    set_config(2'd3, 11'd2);
    for (int row = 0; row < 3; row++) begin
      for (int col = 0; col < 6; col++) begin
        send_pixel(row == 0 && col == 0,
                   (col < 3) ? 8'd255 : 8'd0,
                   (col < 3) ? 8'd0 : 8'd255,
                   (row == 0 && col == 0) ? 8'd5 : ((row == 0 && col == 3) ? 8'd4 : 8'd0));
      end
    end
    drain();
    // 2x2 block, one column: an exact half rounds up
    set_config(2'd2, 11'd1);
    for (int i = 0; i < 4; i++) begin
      send_pixel(i == 0, (i >= 2) ? 8'd1 : 8'd0, (i == 3) ? 8'd254 : 8'd255,
                 (i == 0) ? 8'd1 : 8'd0);
    end
    drain();

    // width above the limit clamps to the largest row, scale 1
    run_phase(2'd1, 11'h7ff, 60);
    // zero scale and zero width act as one
    run_phase(2'd0, 11'd0, 12);
    run_phase(2'd3, 11'd1024, 40);

    while (random_items < RANDOM_ITEMS) begin
      scale = $urandom_range(0, 3);
      case ($urandom_range(0, 9))
        0:       width = $urandom_range(7, 48);
        1:       width = 11'd1;
        default: width = $urandom_range(1, 6);
      endcase
      n_items = $urandom_range(20, 80);
      quiet   = (phase_idx == 4);
      run_phase(scale, width, n_items);
      random_items += n_items;
      phase_idx++;
    end
    quiet = 1'b0;

    $display("sent %0d pixels under %0d register settings, compared %0d output pixels",
             pixels_sent, settings_used, checked_avgs);
    $display("covered scales 0..3, widths 0..2047, frame resyncs and mid-frame lowering");
    if (fail_count == 0) begin
      $display("box_filter_downsampler test passed");
    end else begin
      $display("box_filter_downsampler test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/bfd_pkg.sv
rtl/bfd_div.sv
rtl/box_filter_downsampler.sv
dv/box_filter_downsampler_checker.sv
dv/box_filter_downsampler_tb.sv
